// File: hdl/word_tokenizer_unit_defines.svh
// Assertion macros for the word tokenizer unit.
// Each macro checks an implication on the rising clock edge and is
// disabled while reset is active.
`ifndef WORD_TOKENIZER_UNIT_DEFINES_SVH
`define WORD_TOKENIZER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define WTOK_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("word tokenizer check failed");

// Next-cycle implication
`define WTOK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("word tokenizer check failed");

`else

`define WTOK_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define WTOK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/wtok_pkg.sv
package wtok_pkg;

    // Character and register widths
    localparam int CHAR_W    = 8;
    localparam int MIN_LEN_W = 6;

    // Minimum token length after reset
    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 6'd2;

    // ASCII codes used for classification
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CH_APOS    = 8'h27;

    // Setting this bit turns an upper-case letter into lower case
    localparam logic [CHAR_W-1:0] CASE_BIT   = 8'h20;

endpackage

// File: hdl/wtok_front.sv
`include "word_tokenizer_unit_defines.svh"

module wtok_front #(
    parameter int MAX_TOKEN = 32,
    parameter int LEN_W     = $clog2(MAX_TOKEN + 1),
    parameter int IDX_W     = (MAX_TOKEN > 1) ? $clog2(MAX_TOKEN) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [wtok_pkg::MIN_LEN_W-1:0]      cfg_wdata,
    // byte input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [wtok_pkg::CHAR_W-1:0]         s_tdata,
    input  logic                                s_tlast,
    // token queue
    input  logic                                q_full,
    output logic                                push,
    output logic [LEN_W-1:0]                    push_len,
    // character buffer write port
    output logic                                mem_we,
    output logic [IDX_W:0]                      mem_waddr,
    output logic [wtok_pkg::CHAR_W-1:0]         mem_wdata
);

    localparam int CMP_W = (LEN_W > wtok_pkg::MIN_LEN_W) ? LEN_W : wtok_pkg::MIN_LEN_W;

    logic [wtok_pkg::MIN_LEN_W-1:0] min_len_reg;
    logic [LEN_W-1:0]               cnt_reg, cnt_next;
    logic [LEN_W-1:0]               kept_reg, kept_next;
    logic                           nondig_reg, nondig_next;
    logic                           wr_sel_reg, wr_sel_next;

    logic                           is_upper, is_lower, is_digit, is_apos;
    logic                           joins, has_room, stores, closes, passes, accept;
    logic [LEN_W-1:0]               cnt_inc, cnt_a, kept_a;
    logic                           nondig_a;
    logic [CMP_W-1:0]               min_cmp, cnt_cmp, kept_cmp;

    // Length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= wtok_pkg::MIN_LEN_RESET;
        end
        else if (cfg_we)
        begin
            min_len_reg <= cfg_wdata;
        end
    end

    // Byte classification
    always_comb
    begin
        is_upper = (s_tdata >= wtok_pkg::CH_UPPER_A) && (s_tdata <= wtok_pkg::CH_UPPER_Z);
        is_lower = (s_tdata >= wtok_pkg::CH_LOWER_A) && (s_tdata <= wtok_pkg::CH_LOWER_Z);
        is_digit = (s_tdata >= wtok_pkg::CH_DIGIT_0) && (s_tdata <= wtok_pkg::CH_DIGIT_9);
        is_apos  = (s_tdata == wtok_pkg::CH_APOS);
        joins    = is_upper || is_lower || is_digit || (is_apos && (cnt_reg != '0));
        has_room = (cnt_reg < LEN_W'(MAX_TOKEN));
        stores   = joins && has_room;
        accept   = s_tvalid && s_tready;
    end

    // Token state after the byte joins, then the close decision
    always_comb
    begin
        cnt_inc  = cnt_reg + LEN_W'(1);
        cnt_a    = stores ? cnt_inc : cnt_reg;
        kept_a   = (stores && !is_apos) ? cnt_inc : kept_reg;
        nondig_a = nondig_reg || (stores && !is_digit);
        closes   = !joins || s_tlast;
        min_cmp  = CMP_W'(min_len_reg);
        cnt_cmp  = CMP_W'(cnt_a);
        kept_cmp = CMP_W'(kept_a);
        passes   = closes && nondig_a && (cnt_cmp >= min_cmp) && (kept_cmp >= min_cmp);
    end

    // Outputs toward queue and buffer
    assign s_tready  = !q_full;
    assign push      = accept && passes;
    assign push_len  = kept_a;
    assign mem_we    = accept && stores;
    assign mem_waddr = {wr_sel_reg, cnt_reg[IDX_W-1:0]};
    assign mem_wdata = is_upper ? (s_tdata | wtok_pkg::CASE_BIT) : s_tdata;

    // Next token state
    always_comb
    begin
        cnt_next    = cnt_reg;
        kept_next   = kept_reg;
        nondig_next = nondig_reg;
        wr_sel_next = wr_sel_reg ^ push;
        if (accept)
        begin
            if (closes)
            begin
                cnt_next    = '0;
                kept_next   = '0;
                nondig_next = 1'b0;
            end
            else
            begin
                cnt_next    = cnt_a;
                kept_next   = kept_a;
                nondig_next = nondig_a;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            kept_reg   <= '0;
            nondig_reg <= 1'b0;
            wr_sel_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            kept_reg   <= kept_next;
            nondig_reg <= nondig_next;
            wr_sel_reg <= wr_sel_next;
        end
    end

    // Stripped length never exceeds the stored length
    `WTOK_ASSERT_SAME(a_kept_le_cnt, clk, rst_n, 1'b1, kept_reg <= cnt_reg)
    // A closed token restarts empty
    `WTOK_ASSERT_NEXT(a_close_clears, clk, rst_n, accept && closes, (cnt_reg == '0) && !nondig_reg)

endmodule

// File: hdl/wtok_queue.sv
module wtok_queue #(
    parameter int LEN_W = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [LEN_W-1:0] push_len,
    output logic             full,
    output logic             valid,
    output logic [LEN_W-1:0] head_len,
    input  logic             pop
);

    // Two-entry queue of token lengths, one entry per token buffer
    logic [LEN_W-1:0] len_reg [2];
    logic [1:0]       count_reg, count_next;
    logic             wp_reg, rp_reg;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign head_len = len_reg[rp_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            wp_reg    <= wp_reg ^ push;
            rp_reg    <= rp_reg ^ pop;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            len_reg[wp_reg] <= push_len;
        end
    end

endmodule

// File: hdl/wtok_back.sv
`include "word_tokenizer_unit_defines.svh"

module wtok_back #(
    parameter int MAX_TOKEN = 32,
    parameter int LEN_W     = $clog2(MAX_TOKEN + 1),
    parameter int IDX_W     = (MAX_TOKEN > 1) ? $clog2(MAX_TOKEN) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // character buffer write port
    input  logic                        mem_we,
    input  logic [IDX_W:0]              mem_waddr,
    input  logic [wtok_pkg::CHAR_W-1:0] mem_wdata,
    // token queue head
    input  logic                        q_valid,
    input  logic [LEN_W-1:0]            q_len,
    output logic                        q_pop,
    // character output
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [wtok_pkg::CHAR_W-1:0] m_tdata,
    output logic                        m_tlast
);

    localparam int DEPTH = 2 * (2 ** IDX_W);

    // Two token buffers, selected by the top address bit
    logic [wtok_pkg::CHAR_W-1:0] mem [DEPTH];
    logic [wtok_pkg::CHAR_W-1:0] rd_data_reg;
    logic [wtok_pkg::CHAR_W-1:0] out_data_reg;

    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_sel_reg, rd_sel_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_last_reg, s1_last_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_last_reg;

    logic             out_load, s1_free, issue, issue_last;
    logic [LEN_W-1:0] idx_ext;

    // Pipeline control: read issue, read data stage, output register
    always_comb
    begin
        out_load   = s1_valid_reg && (!out_valid_reg || m_tready);
        s1_free    = !s1_valid_reg || out_load;
        issue      = q_valid && s1_free;
        idx_ext    = LEN_W'(rd_idx_reg);
        issue_last = (idx_ext + LEN_W'(1)) == q_len;
        q_pop      = issue && issue_last;
    end

    always_comb
    begin
        rd_idx_next    = rd_idx_reg;
        rd_sel_next    = rd_sel_reg;
        s1_valid_next  = issue || (s1_valid_reg && !out_load);
        s1_last_next   = issue ? issue_last : s1_last_reg;
        out_valid_next = out_load || (out_valid_reg && !m_tready);
        if (issue)
        begin
            if (issue_last)
            begin
                rd_idx_next = '0;
                rd_sel_next = !rd_sel_reg;
            end
            else
            begin
                rd_idx_next = rd_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            rd_sel_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            rd_idx_reg    <= rd_idx_next;
            rd_sel_reg    <= rd_sel_next;
            s1_valid_reg  <= s1_valid_next;
            s1_last_reg   <= s1_last_next;
            out_valid_reg <= out_valid_next;
            if (out_load)
            begin
                out_last_reg <= s1_last_reg;
            end
        end
    end

    // Buffer memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue)
        begin
            rd_data_reg <= mem[{rd_sel_reg, rd_idx_reg}];
        end
    end

    // Output data register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= rd_data_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Read index stays inside the token at the queue head
    `WTOK_ASSERT_SAME(a_idx_in_token, clk, rst_n, q_valid, idx_ext < q_len)
    // A token leaves the queue only from the read stage it feeds
    `WTOK_ASSERT_NEXT(a_pop_marks_last, clk, rst_n, q_pop, s1_valid_reg && s1_last_reg)

endmodule

// File: hdl/word_tokenizer_unit.sv
// Channel   | Group      | Payload (low bit first)                | Notes
// ----------+------------+----------------------------------------+-----------------------
// text in   | s_t*       | tdata: text_byte[7:0]; tlast: end_of_text | one byte per transfer
// token out | m_t*       | tdata: token_char[7:0]; tlast: token_last | one char per transfer
// config    | cfg_we/... | cfg_wdata: min_length[5:0]             | write when idle only
//
// A byte is taken each cycle while fewer than two finished tokens wait to be sent;
// the two token buffers behind a two-entry length queue set this limit.
// Characters leave one per cycle while m_tready is high, through a read stage and an
// output register; a closed token passes the length queue and both before it is seen.
// Reset (rst_n, asynchronous, active low) empties the token, the queue and the
// output; min_length returns to 2. No clearing pass is needed.
module word_tokenizer_unit #(
    parameter int MAX_TOKEN = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [5:0] cfg_wdata,   // min_length[5:0]
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // text_byte[7:0]
    input  logic       s_tlast,     // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // token_char[7:0]
    output logic       m_tlast      // token_last
);

    localparam int LEN_W = $clog2(MAX_TOKEN + 1);
    localparam int IDX_W = (MAX_TOKEN > 1) ? $clog2(MAX_TOKEN) : 1;

    logic                        push, q_full, q_valid, q_pop;
    logic [LEN_W-1:0]            push_len, q_len;
    logic                        mem_we;
    logic [IDX_W:0]              mem_waddr;
    logic [wtok_pkg::CHAR_W-1:0] mem_wdata;

    // Classifier and token builder
    wtok_front #(
        .MAX_TOKEN (MAX_TOKEN),
        .LEN_W     (LEN_W),
        .IDX_W     (IDX_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_len  (push_len),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata)
    );

    // Finished-token queue
    wtok_queue #(
        .LEN_W (LEN_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_len (push_len),
        .full     (q_full),
        .valid    (q_valid),
        .head_len (q_len),
        .pop      (q_pop)
    );

    // Buffer and character emitter
    wtok_back #(
        .MAX_TOKEN (MAX_TOKEN),
        .LEN_W     (LEN_W),
        .IDX_W     (IDX_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .q_valid   (q_valid),
        .q_len     (q_len),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// File: verif/word_tokenizer_unit_tb.sv
`timescale 1ns / 100ps

module word_tokenizer_unit_tb;

    localparam int MAX_TOK     = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 8;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } token_char_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [5:0] cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    // Predictor state: the word being built and the current minimum length
    logic [7:0]                     word_buf [MAX_TOK];
    int                             word_len;
    int                             kept_len;
    logic                           has_nondigit;
    logic [wtok_pkg::MIN_LEN_W-1:0] min_len;

    token_char_t pending_chars[$];
    int          mismatch_count;
    int          cycle_count;
    bit          calm;

    word_tokenizer_unit #(.MAX_TOKEN(MAX_TOK)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Close the current word; queue its stripped characters if it qualifies
    task automatic close_word();
        if (word_len >= int'(min_len) && has_nondigit && kept_len >= int'(min_len))
        begin
            for (int i = 0; i < kept_len; i++)
            begin
                pending_chars.push_back('{ch: word_buf[i], last: (i == kept_len - 1)});
            end
        end
        word_len     = 0;
        kept_len     = 0;
        has_nondigit = 1'b0;
    endtask

    // Advance the predictor by one accepted text byte
    task automatic take_byte(input logic [7:0] b, input logic eot);
        logic is_up;
        logic is_lo;
        logic is_dig;
        logic is_apos;
        is_up   = (b >= wtok_pkg::CH_UPPER_A) && (b <= wtok_pkg::CH_UPPER_Z);
        is_lo   = (b >= wtok_pkg::CH_LOWER_A) && (b <= wtok_pkg::CH_LOWER_Z);
        is_dig  = (b >= wtok_pkg::CH_DIGIT_0) && (b <= wtok_pkg::CH_DIGIT_9);
        is_apos = (b == wtok_pkg::CH_APOS);
        if (is_up || is_lo || is_dig || (is_apos && word_len > 0))
        begin
            if (word_len < MAX_TOK)
            begin
                word_buf[word_len] = is_up ? (b | wtok_pkg::CASE_BIT) : b;
                word_len++;
                if (!is_dig)
                    has_nondigit = 1'b1;
                if (!is_apos)
                    kept_len = word_len;
            end
        end
        else
        begin
            close_word();
        end
        if (eot)
            close_word();
    endtask

    // Output checker and input monitor
    always @(posedge clk)
    begin
        token_char_t exp_c;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_chars.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected char transfer, expected none, actual char %h last %b",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                exp_c = pending_chars.pop_front();
                if (m_tdata !== exp_c.ch)
                begin
                    mismatch_count++;
                    $display("%0t: token_char expected %h actual %h", $time, exp_c.ch, m_tdata);
                end
                if (m_tlast !== exp_c.last)
                begin
                    mismatch_count++;
                    $display("%0t: token_last expected %b actual %b",
                             $time, exp_c.last, m_tlast);
                end
            end
        end
        if (rst_n && s_tvalid && s_tready)
            take_byte(s_tdata, s_tlast);
    end

    // Random back-pressure on the token side
    always @(posedge clk)
    begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // One text transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while (!calm && $urandom_range(99) < 32)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_text(input string s, input bit eot_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eot_at_end && (i == s.len() - 1));
    endtask

    // Hold off the sender until every predicted char has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_chars.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Close any open word, wait for idle, then write min_length
    task automatic set_min_len(input logic [wtok_pkg::MIN_LEN_W-1:0] v);
        send_byte(" ", 1'b0);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        min_len   = v;
    endtask

    function automatic logic [7:0] rand_delim();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (((b >= wtok_pkg::CH_UPPER_A) && (b <= wtok_pkg::CH_UPPER_Z)) ||
               ((b >= wtok_pkg::CH_LOWER_A) && (b <= wtok_pkg::CH_LOWER_Z)) ||
               ((b >= wtok_pkg::CH_DIGIT_0) && (b <= wtok_pkg::CH_DIGIT_9)) ||
               (b == wtok_pkg::CH_APOS));
        return b;
    endfunction

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return 8'(wtok_pkg::CH_LOWER_A + $urandom_range(25));
        else if (r < 58)
            return 8'(wtok_pkg::CH_UPPER_A + $urandom_range(25));
        else if (r < 85)
            return 8'(wtok_pkg::CH_DIGIT_0 + $urandom_range(9));
        else
            return wtok_pkg::CH_APOS;
    endfunction

    // Class boundaries, zero byte, 0xFF and the end-of-text flush
    task automatic test_char_classes();
        send_text("AZ@az`09/:{", 1'b0);
        send_byte(8'h5B, 1'b0);
        send_text("Mx", 1'b0);
        send_byte(8'h00, 1'b0);
        send_text("9a", 1'b1);
        send_byte(8'hFF, 1'b1);
    endtask

    // Leading apostrophe ignored, trailing ones stripped
    task automatic test_apostrophes();
        send_text("'Zz'' ", 1'b0);
        send_text("o'k'", 1'b1);
        send_text("x'' ", 1'b0);
    endtask

    // Over-long word: apostrophe lands in the last slot, rest is dropped
    task automatic test_truncation();
        for (int i = 0; i < MAX_TOK - 1; i++)
            send_byte(8'(wtok_pkg::CH_UPPER_A + (i % 26)), 1'b0);
        send_byte(wtok_pkg::CH_APOS, 1'b0);
        send_text("bc9", 1'b0);
        send_byte(" ", 1'b0);
    endtask

    // Register extremes: zero, the buffer size, above it, all ones
    task automatic test_min_extremes();
        set_min_len(6'd0);
        send_text("q", 1'b1);
        send_text("5", 1'b1);
        send_text("' ", 1'b1);
        set_min_len(6'd32);
        for (int i = 0; i < MAX_TOK; i++)
            send_byte(8'(wtok_pkg::CH_LOWER_A + (i % 26)), 1'b0);
        send_byte(".", 1'b0);
        set_min_len(6'd33);
        for (int i = 0; i < MAX_TOK; i++)
            send_byte(8'(wtok_pkg::CH_LOWER_A + (i % 26)), i == MAX_TOK - 1);
        set_min_len(6'd63);
        send_text("abcdef ", 1'b0);
    endtask

    // Mostly well-formed words with random content, some raw noise
    task automatic test_random_text(input int n_bytes, input bit mid_pause);
        int sent;
        int wlen;
        int paused;
        sent   = 0;
        paused = 0;
        while (sent < n_bytes)
        begin
            if ($urandom_range(99) < 78)
            begin
                if ($urandom_range(99) < 10)
                begin
                    send_byte(wtok_pkg::CH_APOS, 1'b0);
                    sent++;
                end
                wlen = ($urandom_range(99) < 5) ? $urandom_range(30, 40) : $urandom_range(1, 9);
                send_byte(8'(($urandom_range(1)) ? wtok_pkg::CH_LOWER_A + $urandom_range(25)
                                                 : wtok_pkg::CH_DIGIT_0 + $urandom_range(9)),
                          1'b0);
                for (int i = 1; i < wlen; i++)
                    send_byte(rand_word_char(), 1'b0);
                if ($urandom_range(99) < 20)
                begin
                    send_byte(wtok_pkg::CH_APOS, 1'b0);
                    sent++;
                end
                sent += wlen;
                if ($urandom_range(99) < 8)
                    send_byte(rand_delim(), 1'b1);
                else
                    send_byte(rand_delim(), 1'b0);
                sent++;
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    send_byte(8'($urandom_range(255)), $urandom_range(99) < 10);
                    sent++;
                end
            end
            if (mid_pause && paused == 0 && sent >= n_bytes / 2)
            begin
                drain();
                paused = 1;
            end
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tlast        <= 1'b0;
        calm           = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        word_len       = 0;
        kept_len       = 0;
        has_nondigit   = 1'b0;
        min_len        = wtok_pkg::MIN_LEN_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_char_classes();
        test_apostrophes();
        test_truncation();
        test_min_extremes();

        set_min_len(6'd2);
        test_random_text(15, 1'b1);
        set_min_len(6'd1);
        test_random_text(12, 1'b0);
        set_min_len(6'd3);
        calm = 1'b1;
        test_random_text(15, 1'b0);
        calm = 1'b0;
        set_min_len(6'($urandom_range(4, 6)));
        test_random_text(12, 1'b0);

        // Flush the last word and let the output settle
        send_byte(" ", 1'b1);
        drain();
        repeat (SETTLE) @(posedge clk);
        if (pending_chars.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: %0d chars expected but never sent", $time, pending_chars.size());
        end
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
